// File: rtl/core/char_lcd_nibble_write_controller_core_defines.svh
// Assertion macros for the checker file of the LCD controller core.
// Depends on nothing; expects clk and rst in the scope of each use.
`ifndef CHAR_LCD_NIBBLE_WRITE_CONTROLLER_CORE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LCDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcdc check failed");

// Next-cycle implication, disabled in reset.
`define LCDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcdc check failed");

`endif

// File: rtl/core/lcdc_pkg.sv
// Types, constants and table functions for the character LCD nibble controller.
// Depends on nothing; used by the sequencer, the top level and the checker.
package lcdc_pkg;

  localparam int unsigned CNT_W       = 20;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned REG_INDEX_W = 3;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_PWR,
    PH_NPULSE,
    PH_NWAIT,
    PH_HI,
    PH_GAP,
    PH_LO,
    PH_SETTLE,
    PH_CLEAR
  } phase_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_INSTR,
    CMD_DATA,
    CMD_INIT
  } command_t;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_ENABLE_PULSE,
    REG_WRITE_SETTLE,
    REG_CLEAR_EXTRA,
    REG_POWERUP,
    REG_INIT_LONG,
    REG_INIT_SHORT
  } reg_index_t;

  localparam logic [15:0] RST_ENABLE_PULSE = 16'd50;
  localparam logic [15:0] RST_WRITE_SETTLE = 16'd50;
  localparam logic [15:0] RST_CLEAR_EXTRA  = 16'd1600;
  localparam logic [19:0] RST_POWERUP      = 20'd1020000;
  localparam logic [15:0] RST_INIT_LONG    = 16'd5000;
  localparam logic [15:0] RST_INIT_SHORT   = 16'd200;

  localparam logic [7:0] CLEAR_INSTR = 8'h01;

  // init_step: 1..4 single nibbles, 5..9 init instruction bytes
  localparam logic [3:0] STEP_FIRST_NIBBLE = 4'd1;
  localparam logic [3:0] STEP_LAST_NIBBLE  = 4'd4;
  localparam logic [3:0] STEP_FIRST_BYTE   = 4'd5;
  localparam logic [3:0] STEP_LAST_CHAIN   = 4'd8;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
  } cmd_t;

  typedef struct packed {
    logic [3:0] bus_nibble;
    logic       select_line;
    logic       enable_line;
    logic       busy_res;
    logic       accepted;
  } rsp_t;

  typedef struct packed {
    logic [15:0] enable_pulse_ticks;
    logic [15:0] write_settle_ticks;
    logic [15:0] clear_extra_ticks;
    logic [19:0] powerup_ticks;
    logic [15:0] init_long_ticks;
    logic [15:0] init_short_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] countdown;
    logic [7:0]       held_byte;
    logic [3:0]       init_step;
    logic [3:0]       nibble;
    logic             select;
    logic             enable;
  } state_t;

  function automatic logic [3:0] init_nibble(logic [1:0] idx);
    logic [3:0] n;
    case (idx)
      2'd3:    n = 4'h2;
      default: n = 4'h3;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] init_byte(logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h08;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h06;
      default: b = 8'h0C;
    endcase
    return b;
  endfunction

  function automatic logic [CNT_W-1:0] at_least_one(logic [15:0] v);
    logic [CNT_W-1:0] r;
    r = (v == 16'd0) ? CNT_W'(1) : CNT_W'(v);
    return r;
  endfunction

endpackage

// File: rtl/core/char_lcd_nibble_write_controller_core.sv
// Top level of the 4-bit character LCD controller: state, config and result registers.
// Depends on lcdc_pkg and lcdc_seq.
//
//   channel | signals                        | direction
//   --------+--------------------------------+----------
//   request | cmd_valid, cmd_stall, cmd_data | in
//   result  | rsp_valid, rsp_stall, rsp_data | out
//   config  | cfg_we, cfg_index, cfg_wdata   | in
//
// One request is taken per clock while cmd_stall is low; its result is in the output
// register on the next cycle. The sequencer step is a single pass through lcdc_seq.
// A request is held off only while the output register is full and stalled.
// Synchronous reset restores the register defaults and the idle phase.
module char_lcd_nibble_write_controller_core import lcdc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  cmd_t                   cmd_data,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output rsp_t                   rsp_data,
  input  logic                   cfg_we,
  input  logic [REG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  rsp_t   rsp_next;
  logic   take;

  assign cmd_stall = rsp_valid & rsp_stall;
  assign take      = cmd_valid & ~cmd_stall;

  lcdc_seq u_seq (
    .st      (st),
    .cfg     (cfg),
    .cmd     (cmd_data),
    .st_next (st_next),
    .rsp     (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_pulse_ticks <= RST_ENABLE_PULSE;
      cfg.write_settle_ticks <= RST_WRITE_SETTLE;
      cfg.clear_extra_ticks  <= RST_CLEAR_EXTRA;
      cfg.powerup_ticks      <= RST_POWERUP;
      cfg.init_long_ticks    <= RST_INIT_LONG;
      cfg.init_short_ticks   <= RST_INIT_SHORT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE_PULSE: cfg.enable_pulse_ticks <= cfg_wdata[15:0];
        REG_WRITE_SETTLE: cfg.write_settle_ticks <= cfg_wdata[15:0];
        REG_CLEAR_EXTRA:  cfg.clear_extra_ticks  <= cfg_wdata[15:0];
        REG_POWERUP:      cfg.powerup_ticks      <= cfg_wdata[19:0];
        REG_INIT_LONG:    cfg.init_long_ticks    <= cfg_wdata[15:0];
        REG_INIT_SHORT:   cfg.init_short_ticks   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase     <= PH_IDLE;
      st.countdown <= '0;
      st.held_byte <= '0;
      st.init_step <= '0;
      st.nibble    <= '0;
      st.select    <= 1'b0;
      st.enable    <= 1'b0;
      rsp_valid    <= 1'b0;
    end else if (take) begin
      st        <= st_next;
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload register: load on every taken request
  always_ff @(posedge clk) begin
    if (take) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

// File: rtl/core/lcdc_seq.sv
// Next-state and result logic of the LCD sequencer for one tick.
// Depends on lcdc_pkg.
module lcdc_seq import lcdc_pkg::*; (
  input  state_t st,
  input  cfg_t   cfg,
  input  cmd_t   cmd,
  output state_t st_next,
  output rsp_t   rsp
);

  function automatic state_t start_byte(state_t s, logic [7:0] b, logic [15:0] pulse);
    state_t r;
    r           = s;
    r.held_byte = b;
    r.nibble    = b[7:4];
    r.enable    = 1'b1;
    r.phase     = PH_HI;
    r.countdown = at_least_one(pulse);
    return r;
  endfunction

  function automatic state_t start_nibble(state_t s, logic [15:0] pulse);
    state_t r;
    r           = s;
    r.nibble    = init_nibble(2'(s.init_step - 4'd1));
    r.select    = 1'b0;
    r.enable    = 1'b1;
    r.phase     = PH_NPULSE;
    r.countdown = at_least_one(pulse);
    return r;
  endfunction

  function automatic state_t go_idle(state_t s);
    state_t r;
    r           = s;
    r.init_step = '0;
    r.enable    = 1'b0;
    r.phase     = PH_IDLE;
    r.countdown = '0;
    return r;
  endfunction

  // chain to the next init instruction, or drop back to idle
  function automatic state_t finish_byte(state_t s, logic [15:0] pulse);
    state_t r;
    r = s;
    if (s.init_step >= STEP_FIRST_BYTE && s.init_step <= STEP_LAST_CHAIN) begin
      r.init_step = s.init_step + 4'd1;
      r = start_byte(r, init_byte(3'(r.init_step - STEP_FIRST_BYTE)), pulse);
    end else begin
      r = go_idle(s);
    end
    return r;
  endfunction

  state_t nx;
  logic   acc;

  always_comb begin
    nx  = st;
    acc = 1'b0;
    if (st.phase != PH_IDLE) begin
      if (st.countdown > CNT_W'(1)) begin
        nx.countdown = st.countdown - CNT_W'(1);
      end else begin
        case (st.phase)
          PH_PWR: begin
            nx.init_step = STEP_FIRST_NIBBLE;
            nx = start_nibble(nx, cfg.enable_pulse_ticks);
          end
          PH_NPULSE: begin
            nx.enable    = 1'b0;
            nx.phase     = PH_NWAIT;
            nx.countdown = at_least_one((st.init_step == STEP_FIRST_NIBBLE) ?
                                        cfg.init_long_ticks : cfg.init_short_ticks);
          end
          PH_NWAIT: begin
            if (st.init_step >= STEP_FIRST_NIBBLE && st.init_step < STEP_LAST_NIBBLE) begin
              nx.init_step = st.init_step + 4'd1;
              nx = start_nibble(nx, cfg.enable_pulse_ticks);
            end else begin
              nx.init_step = STEP_FIRST_BYTE;
              nx.select    = 1'b0;
              nx = start_byte(nx, init_byte(3'd0), cfg.enable_pulse_ticks);
            end
          end
          PH_HI: begin
            nx.enable    = 1'b0;
            nx.phase     = PH_GAP;
            nx.countdown = CNT_W'(1);
          end
          PH_GAP: begin
            nx.nibble    = st.held_byte[3:0];
            nx.enable    = 1'b1;
            nx.phase     = PH_LO;
            nx.countdown = at_least_one(cfg.enable_pulse_ticks);
          end
          PH_LO: begin
            nx.enable    = 1'b0;
            nx.phase     = PH_SETTLE;
            nx.countdown = at_least_one(cfg.write_settle_ticks);
          end
          PH_SETTLE: begin
            // clear display needs the extra wait
            if (!st.select && st.held_byte == CLEAR_INSTR && cfg.clear_extra_ticks != 16'd0) begin
              nx.phase     = PH_CLEAR;
              nx.countdown = CNT_W'(cfg.clear_extra_ticks);
            end else begin
              nx = finish_byte(st, cfg.enable_pulse_ticks);
            end
          end
          PH_CLEAR: nx = finish_byte(st, cfg.enable_pulse_ticks);
          default:  nx = go_idle(st);
        endcase
      end
    end else if (cmd.command != CMD_TICK) begin
      acc          = 1'b1;
      nx.init_step = '0;
      if (cmd.command == CMD_INIT) begin
        nx.select = 1'b0;
        if (cfg.powerup_ticks != 20'd0) begin
          nx.enable    = 1'b0;
          nx.phase     = PH_PWR;
          nx.countdown = CNT_W'(cfg.powerup_ticks);
        end else begin
          nx.init_step = STEP_FIRST_NIBBLE;
          nx = start_nibble(nx, cfg.enable_pulse_ticks);
        end
      end else begin
        nx.select = (cmd.command == CMD_DATA);
        nx = start_byte(nx, cmd.byte_value, cfg.enable_pulse_ticks);
      end
    end
  end

  assign st_next         = nx;
  assign rsp.bus_nibble  = nx.nibble;
  assign rsp.select_line = nx.select;
  assign rsp.enable_line = nx.enable;
  assign rsp.busy_res    = (nx.phase != PH_IDLE);
  assign rsp.accepted    = acc;

endmodule

// File: rtl/core/lcdc_checker.sv
// Port-level checks for the LCD controller core, bound to the top level.
// Depends on lcdc_pkg and char_lcd_nibble_write_controller_core_defines.svh.
`include "char_lcd_nibble_write_controller_core_defines.svh"

module lcdc_checker import lcdc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input cmd_t cmd_data,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp_data
);

  // a full, stalled result register must hold off requests
  `LCDC_ASSERT_IMP(a_stall_back, rsp_valid && rsp_stall, cmd_stall)
  // a stalled request stays put
  `LCDC_ASSERT_NXT(a_req_hold, cmd_valid && cmd_stall, cmd_valid && $stable(cmd_data))
  // a stalled result stays put
  `LCDC_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
  // enable only pulses inside a running sequence
  `LCDC_ASSERT_IMP(a_en_busy, rsp_valid && rsp_data.enable_line, rsp_data.busy_res)
  // a taken command always starts a sequence
  `LCDC_ASSERT_IMP(a_acc_busy, rsp_valid && rsp_data.accepted, rsp_data.busy_res)

endmodule

bind char_lcd_nibble_write_controller_core lcdc_checker u_lcdc_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd_data  (cmd_data),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);

// File: dv/char_lcd_nibble_write_controller_core_tb.sv
// Self-checking bench for the 4-bit character LCD controller core: it drives requests and
// config writes, and checks every result against a cycle-exact model of the sequencer.
// Depends on lcdc_pkg and char_lcd_nibble_write_controller_core.
module char_lcd_nibble_write_controller_core_tb;
  import lcdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 100_000;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned RANDOM_PASSES = 8;

  // power-up nibbles 3,3,3,2 and setup bytes 28,08,01,06,0C, lowest slot first
  localparam bit [15:0] WAKE_NIBBLES = 16'h2333;
  localparam bit [39:0] SETUP_BYTES  = 40'h0C_06_01_08_28;

  localparam logic [REG_INDEX_W-1:0] FIRST_SPARE_INDEX = REG_INDEX_W'(REG_INIT_SHORT + 1);
  localparam logic [REG_INDEX_W-1:0] LAST_SPARE_INDEX  = '1;
  localparam logic [CFG_DATA_W-1:0]  MAX_TICKS20       = '1;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  class lcd_scoreboard;
    cfg_t        regs;
    phase_t      ph;
    bit [20:0]   count;
    bit [7:0]    held;
    bit [3:0]    step;
    bit [3:0]    nibble;
    bit          sel;
    bit          en;
    rsp_t        expected_q[$];
    int unsigned errors;

    function new();
      regs.enable_pulse_ticks = RST_ENABLE_PULSE;
      regs.write_settle_ticks = RST_WRITE_SETTLE;
      regs.clear_extra_ticks  = RST_CLEAR_EXTRA;
      regs.powerup_ticks      = RST_POWERUP;
      regs.init_long_ticks    = RST_INIT_LONG;
      regs.init_short_ticks   = RST_INIT_SHORT;
      ph     = PH_IDLE;
      count  = '0;
      held   = '0;
      step   = '0;
      nibble = '0;
      sel    = 1'b0;
      en     = 1'b0;
      errors = 0;
    endfunction

    // a zero wait still has to let enable fall
    function bit [20:0] min_one(bit [15:0] v);
      return (v == 16'd0) ? 21'd1 : 21'(v);
    endfunction

    function void load_byte(bit [7:0] b);
      held   = b;
      nibble = b[7:4];
      en     = 1'b1;
      ph     = PH_HI;
      count  = min_one(regs.enable_pulse_ticks);
    endfunction

    function void load_nibble();
      bit [1:0] slot;
      slot   = 2'(step - 4'd1);
      nibble = WAKE_NIBBLES[slot*4 +: 4];
      sel    = 1'b0;
      en     = 1'b1;
      ph     = PH_NPULSE;
      count  = min_one(regs.enable_pulse_ticks);
    endfunction

    function void go_idle();
      step  = '0;
      en    = 1'b0;
      ph    = PH_IDLE;
      count = '0;
    endfunction

    function void finish_byte();
      if (step >= STEP_FIRST_BYTE && step <= STEP_LAST_CHAIN) begin
        step++;
        load_byte(SETUP_BYTES[int'(step - STEP_FIRST_BYTE)*8 +: 8]);
      end else begin
        go_idle();
      end
    endfunction

    function void advance();
      case (ph)
        PH_PWR: begin
          step = STEP_FIRST_NIBBLE;
          load_nibble();
        end
        PH_NPULSE: begin
          en    = 1'b0;
          ph    = PH_NWAIT;
          count = min_one(step == STEP_FIRST_NIBBLE ? regs.init_long_ticks
                                                    : regs.init_short_ticks);
        end
        PH_NWAIT: begin
          if (step >= STEP_FIRST_NIBBLE && step < STEP_LAST_NIBBLE) begin
            step++;
            load_nibble();
          end else begin
            step = STEP_FIRST_BYTE;
            sel  = 1'b0;
            load_byte(SETUP_BYTES[7:0]);
          end
        end
        PH_HI: begin
          en    = 1'b0;
          ph    = PH_GAP;
          count = 21'd1;
        end
        PH_GAP: begin
          nibble = held[3:0];
          en     = 1'b1;
          ph     = PH_LO;
          count  = min_one(regs.enable_pulse_ticks);
        end
        PH_LO: begin
          en    = 1'b0;
          ph    = PH_SETTLE;
          count = min_one(regs.write_settle_ticks);
        end
        PH_SETTLE: begin
          // clear display needs the extra wait, unless it is set to nothing
          if (!sel && held == CLEAR_INSTR && regs.clear_extra_ticks != 16'd0) begin
            ph    = PH_CLEAR;
            count = 21'(regs.clear_extra_ticks);
          end else begin
            finish_byte();
          end
        end
        PH_CLEAR: finish_byte();
        default:  go_idle();
      endcase
    endfunction

    // one clock tick of the sequencer for one accepted request
    function rsp_t lcd_tick(cmd_t c);
      rsp_t r;
      r.accepted = 1'b0;
      if (ph != PH_IDLE) begin
        if (count > 21'd1) count--;
        else advance();
      end else if (c.command != CMD_TICK) begin
        r.accepted = 1'b1;
        step = '0;
        if (c.command == CMD_INIT) begin
          sel = 1'b0;
          if (regs.powerup_ticks != 20'd0) begin
            en    = 1'b0;
            ph    = PH_PWR;
            count = 21'(regs.powerup_ticks);
          end else begin
            step = STEP_FIRST_NIBBLE;
            load_nibble();
          end
        end else begin
          sel = (c.command == CMD_DATA);
          load_byte(c.byte_value);
        end
      end
      r.bus_nibble  = nibble;
      r.select_line = sel;
      r.enable_line = en;
      r.busy_res    = (ph != PH_IDLE);
      return r;
    endfunction

    function void note_request(cmd_t c);
      expected_q.push_back(lcd_tick(c));
    endfunction

    function void set_register(logic [REG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ENABLE_PULSE: regs.enable_pulse_ticks = value[15:0];
        REG_WRITE_SETTLE: regs.write_settle_ticks = value[15:0];
        REG_CLEAR_EXTRA:  regs.clear_extra_ticks  = value[15:0];
        REG_POWERUP:      regs.powerup_ticks      = value[19:0];
        REG_INIT_LONG:    regs.init_long_ticks    = value[15:0];
        REG_INIT_SHORT:   regs.init_short_ticks   = value[15:0];
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        $error("result %h with no request outstanding", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("bus_nibble", want.bus_nibble, got.bus_nibble);
      compare_field("select_line", 4'(want.select_line), 4'(got.select_line));
      compare_field("enable_line", 4'(want.enable_line), 4'(got.enable_line));
      compare_field("busy_res", 4'(want.busy_res), 4'(got.busy_res));
      compare_field("accepted", 4'(want.accepted), 4'(got.accepted));
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cmd_valid;
  logic                   cmd_stall;
  cmd_t                   cmd_data;
  logic                   rsp_valid;
  logic                   rsp_stall;
  rsp_t                   rsp_data;
  logic                   cfg_we;
  logic [REG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  lcd_scoreboard sb = new();
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   cycles = 0;

  char_lcd_nibble_write_controller_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("char_lcd_nibble_write_controller_core_tb NOT OK");
      $finish;
    end
  end

  // result side: stall at random, check on every accepted result
  always @(negedge clk) begin
    if (!rst) rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
  end

  function automatic cmd_t make_request(command_t op, logic [7:0] b);
    cmd_t c;
    c.command    = op;
    c.byte_value = b;
    return c;
  endfunction

  // mostly well-formed: commands while idle, ticks while a sequence runs, some noise
  function automatic cmd_t pick_request(bit seq_busy);
    int unsigned roll;
    command_t    op;
    logic [7:0]  b;
    b    = 8'($urandom);
    roll = $urandom_range(99);
    if (seq_busy && roll < 85) begin
      op = CMD_TICK;
    end else begin
      roll = $urandom_range(99);
      if (roll < 10)      op = CMD_TICK;
      else if (roll < 48) op = CMD_DATA;
      else if (roll < 85) op = CMD_INSTR;
      else                op = CMD_INIT;
      if (op == CMD_INSTR && $urandom_range(3) == 0) b = CLEAR_INSTR;
    end
    return make_request(op, b);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_request(c);
    @(negedge clk);
  endtask

  // drop valid and wait until every result is back
  task automatic quiesce();
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_register(input logic [REG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic write_timing(input logic [CFG_DATA_W-1:0] pulse, settle, clr, pwr,
                              wait_long, wait_short);
    write_register(REG_ENABLE_PULSE, pulse);
    write_register(REG_WRITE_SETTLE, settle);
    write_register(REG_CLEAR_EXTRA, clr);
    write_register(REG_POWERUP, pwr);
    write_register(REG_INIT_LONG, wait_long);
    write_register(REG_INIT_SHORT, wait_short);
  endtask

  // small waits, with junk above bit 15 that the block must drop
  task automatic randomize_timing();
    write_timing({4'($urandom), 16'($urandom_range(4))},
                 {4'($urandom), 16'($urandom_range(4))},
                 {4'($urandom), 16'($urandom_range(6))},
                 20'($urandom_range(8)),
                 {4'($urandom), 16'($urandom_range(6))},
                 {4'($urandom), 16'($urandom_range(4))});
    if ($urandom_range(3) == 0) write_register(FIRST_SPARE_INDEX, 20'($urandom));
  endtask

  // advance the running sequence to idle, with refused commands or plain ticks
  task automatic ride_out(input bit refuse);
    while (sb.busy()) begin
      if (refuse) send_item(make_request(command_t'($urandom_range(1, 3)), 8'($urandom)));
      else send_item(make_request(CMD_TICK, 8'($urandom)));
    end
  endtask

  task automatic set_idling(input idling_t mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 46; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 46; end
      IDLE_BOTH:     begin send_idle_pct = 9;  stall_pct = 9;  end
      default:       begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_data  = '0;
    rsp_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_timing(20'hF0002, 20'd1, 20'd3, 20'd4, 20'd3, 20'd1);
    send_item(make_request(CMD_TICK, 8'hFF));
    // clear, then hammer it with refused writes up to and including the last busy tick
    send_item(make_request(CMD_INSTR, CLEAR_INSTR));
    ride_out(1'b1);
    send_item(make_request(CMD_DATA, 8'hFF));
    ride_out(1'b0);
    send_item(make_request(CMD_DATA, 8'h00));
    ride_out(1'b0);
    send_item(make_request(CMD_DATA, CLEAR_INSTR));
    ride_out(1'b0);
    send_item(make_request(CMD_INSTR, 8'hA5));
    send_item(make_request(CMD_INIT, 8'h00));
    ride_out(1'b0);
    send_item(make_request(CMD_INSTR, 8'h00));
    ride_out(1'b0);
    send_item(make_request(CMD_INIT, 8'hFF));
    ride_out(1'b0);

    // zero waits: pulses and settles take the shortest wait, power-up and clear are skipped
    quiesce();
    write_timing('0, '0, '0, '0, '0, '0);
    write_register(FIRST_SPARE_INDEX, MAX_TICKS20);
    write_register(LAST_SPARE_INDEX, MAX_TICKS20);
    send_item(make_request(CMD_INSTR, CLEAR_INSTR));
    ride_out(1'b0);
    send_item(make_request(CMD_DATA, 8'h5A));
    ride_out(1'b1);
    send_item(make_request(CMD_INIT, 8'h00));
    ride_out(1'b0);

    // retime part way through an init sequence
    quiesce();
    write_register(REG_POWERUP, 20'd6);
    send_item(make_request(CMD_INIT, 8'h00));
    repeat (3) send_item(make_request(CMD_TICK, 8'h00));
    quiesce();
    write_timing(20'd3, 20'd2, 20'd2, 20'd6, 20'd2, 20'd0);
    ride_out(1'b0);

    for (int p = 0; p < RANDOM_PASSES; p++) begin
      quiesce();
      randomize_timing();
      set_idling(idling_t'(p % 4));
      repeat (RANDOM_ITEMS / RANDOM_PASSES) send_item(pick_request(sb.busy()));
    end

    quiesce();
    repeat (4) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("char_lcd_nibble_write_controller_core_tb OK");
    end else begin
      $display("char_lcd_nibble_write_controller_core_tb NOT OK");
    end
    $finish;
  end

endmodule
